// ===== sv/i2cmte_pkg.sv =====
// Shared types, constants and a helper function for the I2C master transaction engine.
// No dependencies; every other file in the sv folder imports this package.
package i2cmte_pkg;

	// Width of the half-bit tick counter and of the wait configuration registers.
	localparam int WAIT_COUNT_BITS = 10;
	localparam int CFG_WAIT_BITS   = 10;
	localparam logic [WAIT_COUNT_BITS-1:0] WAIT_MAX = '1;

	// Width of the configuration register index and of the configuration data.
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = CFG_WAIT_BITS;

	typedef logic [WAIT_COUNT_BITS-1:0] wait_t;
	typedef logic [CFG_WAIT_BITS-1:0]   cfg_wait_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_LOW_WAIT  = 2'd0,
		REG_HIGH_WAIT = 2'd1,
		REG_FAST_MODE = 2'd2
	} cfg_reg_t;

	// Reset values of the configuration registers.
	localparam cfg_wait_t LOW_WAIT_RESET  = 10'd5;
	localparam cfg_wait_t HIGH_WAIT_RESET = 10'd4;

	// Transfer status codes.
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NACK_ADDR = 2'd1;
	localparam logic [1:0] STATUS_NACK_DATA = 2'd2;

	// Shift register fill patterns: all ones releases SDA, all zeros answers ACK.
	localparam logic [7:0] SHIFT_ONES  = 8'hFF;
	localparam logic [7:0] SHIFT_ZEROS = 8'h00;

	// Number of bits in a data slot and in an acknowledge slot.
	localparam logic [3:0] DATA_SLOT_BITS = 4'd8;
	localparam logic [3:0] ACK_SLOT_BITS  = 4'd1;

	typedef enum logic [3:0] {
		PH_IDLE        = 4'd0,
		PH_IDLE_HELD   = 4'd1,
		PH_START_SCL   = 4'd2,
		PH_START_SETUP = 4'd3,
		PH_START_HOLD  = 4'd4,
		PH_BIT_LOW     = 4'd5,
		PH_BIT_SCL     = 4'd6,
		PH_BIT_HIGH    = 4'd7,
		PH_SLOT_TAIL   = 4'd8,
		PH_STOP_SCL    = 4'd9,
		PH_STOP_HOLD   = 4'd10,
		PH_STOP_FREE   = 4'd11
	} phase_t;

	typedef struct packed {
		cfg_wait_t low_wait_ticks;
		cfg_wait_t high_wait_ticks;
		logic      fast_mode;
	} cfg_t;

	typedef struct packed {
		logic       command;
		logic [6:0] target_address;
		logic       read_not_write;
		logic [7:0] byte_count;
		logic [7:0] write_byte;
		logic       scl_in;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_low;
		logic       sda_low;
		logic       busy_res;
		logic       write_taken;
		logic [7:0] read_data;
		logic       read_valid;
		logic       done_res;
		logic [1:0] status;
	} result_t;

	// A wait register of zero counts as one tick; values beyond the counter saturate.
	function automatic wait_t eff_wait(input cfg_wait_t v);
		logic [31:0] r;
		r = (v == '0) ? 32'd1 : 32'(v);
		if (r > 32'(WAIT_MAX)) begin
			r = 32'(WAIT_MAX);
		end
		return r[WAIT_COUNT_BITS-1:0];
	endfunction

endpackage

// ===== sv/i2cmte_engine.sv =====
// Bus sequencer of the I2C master transaction engine: phase state machine, tick counter,
// shift register and byte bookkeeping, advanced by one tick per step. Depends on i2cmte_pkg.
module i2cmte_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  i2cmte_pkg::item_t item,
	input  i2cmte_pkg::cfg_t  cfg,
	output i2cmte_pkg::result_t res
);
	import i2cmte_pkg::*;

	phase_t     phase_q, phase_n;
	wait_t      wait_q, wait_n;
	logic [7:0] shift_q, shift_n;
	logic [3:0] bit_q, bit_n;
	logic [7:0] bytes_q, bytes_n;
	logic       addr_ph_q, addr_ph_n;
	logic       wmode_q, wmode_n;
	logic [1:0] status_q, status_n;
	logic       ack_q, ack_n;

	logic       taken, rvalid, done;
	logic [7:0] rdata;
	logic [7:0] bytes_dec;
	logic [3:0] bit_inc;

	wait_t                  eff_low, eff_high, eff_sel, wait_adv;
	logic [WAIT_COUNT_BITS:0] wait_inc;
	logic                   over;
	logic                   drive;

	assign eff_low  = eff_wait(cfg.low_wait_ticks);
	assign eff_high = eff_wait(cfg.high_wait_ticks);

	// Pick the wait length that applies to the current phase.
	always_comb begin
		case (phase_q)
			PH_START_SETUP: eff_sel = cfg.fast_mode ? eff_high : eff_low;
			PH_START_HOLD, PH_BIT_HIGH, PH_STOP_HOLD: eff_sel = eff_high;
			default: eff_sel = eff_low;
		endcase
	end

	assign wait_inc  = {1'b0, wait_q} + 1'b1;
	assign over      = wait_inc >= {1'b0, eff_sel};
	assign wait_adv  = over ? '0 : wait_inc[WAIT_COUNT_BITS-1:0];
	assign bytes_dec = bytes_q - 8'd1;
	assign bit_inc   = bit_q + 4'd1;

	// Next state.
	always_comb begin
		phase_n   = phase_q;
		wait_n    = wait_q;
		shift_n   = shift_q;
		bit_n     = bit_q;
		bytes_n   = bytes_q;
		addr_ph_n = addr_ph_q;
		wmode_n   = wmode_q;
		status_n  = status_q;
		ack_n     = ack_q;
		taken     = 1'b0;
		rvalid    = 1'b0;
		rdata     = 8'd0;
		done      = 1'b0;
		case (phase_q)
			PH_IDLE, PH_IDLE_HELD: begin
				if (item.command) begin
					shift_n   = {item.target_address, item.read_not_write};
					wmode_n   = !item.read_not_write;
					bytes_n   = item.byte_count;
					addr_ph_n = 1'b1;
					ack_n     = 1'b0;
					bit_n     = 4'd0;
					wait_n    = '0;
					phase_n   = PH_START_SCL;
				end
			end
			PH_START_SCL: begin
				if (item.scl_in) begin
					wait_n  = '0;
					phase_n = PH_START_SETUP;
				end
			end
			PH_START_SETUP: begin
				wait_n = wait_adv;
				if (over) begin
					phase_n = PH_START_HOLD;
				end
			end
			PH_START_HOLD: begin
				wait_n = wait_adv;
				if (over) begin
					ack_n   = 1'b0;
					bit_n   = 4'd0;
					phase_n = PH_BIT_LOW;
				end
			end
			PH_BIT_LOW: begin
				wait_n = wait_adv;
				if (over) begin
					phase_n = PH_BIT_SCL;
				end
			end
			PH_BIT_SCL: begin
				if (item.scl_in) begin
					wait_n  = '0;
					phase_n = PH_BIT_HIGH;
				end
			end
			PH_BIT_HIGH: begin
				wait_n = wait_adv;
				if (over) begin
					// Data is sampled on the last tick of the high half.
					shift_n = {shift_q[6:0], item.sda_in};
					bit_n   = bit_inc;
					phase_n = (bit_inc >= (ack_q ? ACK_SLOT_BITS : DATA_SLOT_BITS)) ?
						PH_SLOT_TAIL : PH_BIT_LOW;
				end
			end
			PH_SLOT_TAIL: begin
				wait_n = wait_adv;
				if (over) begin
					if (!ack_q) begin
						// End of a byte: move to its acknowledge slot.
						ack_n   = 1'b1;
						bit_n   = 4'd0;
						phase_n = PH_BIT_LOW;
						if (!addr_ph_q && !wmode_q) begin
							rdata   = shift_q;
							rvalid  = 1'b1;
							bytes_n = bytes_dec;
							// The last read byte is answered with NACK.
							shift_n = (bytes_dec == 8'd0) ? SHIFT_ONES : SHIFT_ZEROS;
						end else begin
							shift_n = SHIFT_ONES;
						end
					end else if (addr_ph_q || wmode_q) begin
						if (shift_q[0]) begin
							// Target did not acknowledge: abort with SCL held low.
							status_n = addr_ph_q ? STATUS_NACK_ADDR : STATUS_NACK_DATA;
							done     = 1'b1;
							phase_n  = PH_IDLE_HELD;
						end else begin
							addr_ph_n = 1'b0;
							if (bytes_q == 8'd0) begin
								phase_n = PH_STOP_SCL;
							end else begin
								ack_n   = 1'b0;
								bit_n   = 4'd0;
								phase_n = PH_BIT_LOW;
								if (wmode_q) begin
									taken   = 1'b1;
									bytes_n = bytes_dec;
									shift_n = item.write_byte;
								end else begin
									shift_n = SHIFT_ONES;
								end
							end
						end
					end else begin
						if (bytes_q == 8'd0) begin
							phase_n = PH_STOP_SCL;
						end else begin
							ack_n   = 1'b0;
							bit_n   = 4'd0;
							shift_n = SHIFT_ONES;
							phase_n = PH_BIT_LOW;
						end
					end
				end
			end
			PH_STOP_SCL: begin
				if (item.scl_in) begin
					wait_n  = '0;
					phase_n = PH_STOP_HOLD;
				end
			end
			PH_STOP_HOLD: begin
				wait_n = wait_adv;
				if (over) begin
					phase_n = PH_STOP_FREE;
				end
			end
			PH_STOP_FREE: begin
				wait_n = wait_adv;
				if (over) begin
					status_n = STATUS_OK;
					done     = 1'b1;
					phase_n  = PH_IDLE;
				end
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase
	end

	// Line drivers and result fields, taken from the state after this tick.
	assign drive = (ack_n ? (!addr_ph_n && !wmode_n) : (addr_ph_n || wmode_n)) && !shift_n[7];

	always_comb begin
		res             = '0;
		res.write_taken = taken;
		res.read_data   = rdata;
		res.read_valid  = rvalid;
		res.done_res    = done;
		res.status      = status_n;
		res.busy_res    = (phase_n != PH_IDLE) && (phase_n != PH_IDLE_HELD);
		case (phase_n)
			PH_IDLE_HELD: begin
				res.scl_low = 1'b1;
				res.sda_low = 1'b0;
			end
			PH_START_HOLD, PH_STOP_SCL, PH_STOP_HOLD: begin
				res.scl_low = 1'b0;
				res.sda_low = 1'b1;
			end
			PH_BIT_LOW: begin
				res.scl_low = 1'b1;
				res.sda_low = drive;
			end
			PH_BIT_SCL, PH_BIT_HIGH: begin
				res.scl_low = 1'b0;
				res.sda_low = drive;
			end
			PH_SLOT_TAIL: begin
				res.scl_low = 1'b1;
				res.sda_low = 1'b0;
			end
			default: begin
				res.scl_low = 1'b0;
				res.sda_low = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			wait_q    <= '0;
			shift_q   <= SHIFT_ONES;
			bit_q     <= 4'd0;
			bytes_q   <= 8'd0;
			addr_ph_q <= 1'b0;
			wmode_q   <= 1'b0;
			status_q  <= STATUS_OK;
			ack_q     <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_n;
			wait_q    <= wait_n;
			shift_q   <= shift_n;
			bit_q     <= bit_n;
			bytes_q   <= bytes_n;
			addr_ph_q <= addr_ph_n;
			wmode_q   <= wmode_n;
			status_q  <= status_n;
			ack_q     <= ack_n;
		end
	end

`ifndef SYNTH
	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= DATA_SLOT_BITS)
		else $error("bit counter beyond a byte");
	a_ack_bits: assert property (@(posedge clk) disable iff (!arst_n)
		ack_q |-> bit_q <= ACK_SLOT_BITS)
		else $error("acknowledge slot holds more than one bit");
	a_idle_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE || phase_q == PH_IDLE_HELD) |-> wait_q == '0)
		else $error("tick counter not cleared in idle");
`endif

endmodule

// ===== sv/i2c_master_transaction_engine_core.sv =====
// Top level of the I2C master transaction engine: input stage, configuration registers,
// sequencer instance and result register. Depends on i2cmte_pkg and i2cmte_engine.
//
// Usage: every item on the input channel is one system tick. It carries the sampled SCL
// and SDA levels, a start command with address, direction and byte count, and the next
// byte to write. Every accepted item yields exactly one result item on the output
// channel: the SCL and SDA pull-down enables, busy, write_taken, a received byte with its
// valid flag, and done with the status of the last finished transfer.
// Both channels use valid and stall; an item moves at a clock edge with valid high and
// stall low. The result of an item passes through the input register and then the
// result register before it shows on the output, and the block takes one item every
// cycle while the receiver does not stall: the input register feeds the sequencer, whose
// next state and result are formed in one pass and land in the result register.
// When the receiver stalls, the held result stays put while one more item is taken into
// the input register; after that in_stall rises until the result is taken.
// The configuration port writes low_wait_ticks (index 0), high_wait_ticks (index 1) and
// fast_mode (index 2) on any edge with cfg_write_en high; other indexes are ignored.
// Reset (arst_n low, asynchronous) empties both stages, returns the sequencer to idle with
// both lines released, and loads the wait registers with 5 and 4 ticks and fast_mode 0.
module i2c_master_transaction_engine_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   command,
	input  logic [6:0]                             target_address,
	input  logic                                   read_not_write,
	input  logic [7:0]                             byte_count,
	input  logic [7:0]                             write_byte,
	input  logic                                   scl_in,
	input  logic                                   sda_in,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   scl_low,
	output logic                                   sda_low,
	output logic                                   busy_res,
	output logic                                   write_taken,
	output logic [7:0]                             read_data,
	output logic                                   read_valid,
	output logic                                   done_res,
	output logic [1:0]                             status,
	input  logic                                   cfg_write_en,
	input  logic [i2cmte_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [i2cmte_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import i2cmte_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    vld_s1;
	result_t res_s2;
	logic    vld_s2;
	result_t res_next;
	logic    accept;
	logic    adv_s1;

	// The input stage moves on whenever the result register is empty or being emptied.
	assign adv_s1   = vld_s1 && (!vld_s2 || !out_stall);
	assign in_stall = vld_s1 && vld_s2 && out_stall;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_wait_ticks  <= LOW_WAIT_RESET;
			cfg_q.high_wait_ticks <= HIGH_WAIT_RESET;
			cfg_q.fast_mode       <= 1'b0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_LOW_WAIT:  cfg_q.low_wait_ticks  <= cfg_data[CFG_WAIT_BITS-1:0];
				REG_HIGH_WAIT: cfg_q.high_wait_ticks <= cfg_data[CFG_WAIT_BITS-1:0];
				REG_FAST_MODE: cfg_q.fast_mode       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.command        <= command;
			item_s1.target_address <= target_address;
			item_s1.read_not_write <= read_not_write;
			item_s1.byte_count     <= byte_count;
			item_s1.write_byte     <= write_byte;
			item_s1.scl_in         <= scl_in;
			item_s1.sda_in         <= sda_in;
		end
	end

	i2cmte_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_next)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s1) begin
			vld_s2 <= 1'b1;
		end else if (!out_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid   = vld_s2;
	assign scl_low     = res_s2.scl_low;
	assign sda_low     = res_s2.sda_low;
	assign busy_res    = res_s2.busy_res;
	assign write_taken = res_s2.write_taken;
	assign read_data   = res_s2.read_data;
	assign read_valid  = res_s2.read_valid;
	assign done_res    = res_s2.done_res;
	assign status      = res_s2.status;

`ifndef SYNTH
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a blocked result");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(done_res && busy_res))
		else $error("transfer reported done while still busy");
	a_data_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (write_taken || read_valid)) |-> busy_res)
		else $error("data byte moved outside a transfer");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for i2c_master_transaction_engine_core: drives bus ticks and predicts
// every result with its own model of the sequencer. Depends on i2cmte_pkg and the core RTL.
module testbench;
	import i2cmte_pkg::*;

	// Clock and the single reset at the start of the run.
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Every input of the block starts at a known value.
	logic                      in_valid       = 1'b0;
	logic                      command        = 1'b0;
	logic [6:0]                target_address = '0;
	logic                      read_not_write = 1'b0;
	logic [7:0]                byte_count     = '0;
	logic [7:0]                write_byte     = '0;
	logic                      scl_in         = 1'b1;
	logic                      sda_in         = 1'b1;
	logic                      out_stall      = 1'b0;
	logic                      cfg_write_en   = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index      = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data       = '0;

	logic       in_stall;
	logic       out_valid;
	logic       scl_low;
	logic       sda_low;
	logic       busy_res;
	logic       write_taken;
	logic [7:0] read_data;
	logic       read_valid;
	logic       done_res;
	logic [1:0] status;

	i2c_master_transaction_engine_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.target_address (target_address),
		.read_not_write (read_not_write),
		.byte_count     (byte_count),
		.write_byte     (write_byte),
		.scl_in         (scl_in),
		.sda_in         (sda_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.scl_low        (scl_low),
		.sda_low        (sda_low),
		.busy_res       (busy_res),
		.write_taken    (write_taken),
		.read_data      (read_data),
		.read_valid     (read_valid),
		.done_res       (done_res),
		.status         (status),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// Bench copy of the configuration registers, loaded with their reset values.
	cfg_wait_t cfg_low  = LOW_WAIT_RESET;
	cfg_wait_t cfg_high = HIGH_WAIT_RESET;
	logic      cfg_fast = 1'b0;

	// Bench copy of the sequencer state.
	phase_t     bus_phase       = PH_IDLE;
	wait_t      tick_count      = '0;
	logic [7:0] shifter         = SHIFT_ONES;
	logic [3:0] bits_done       = '0;
	logic [7:0] bytes_remaining = '0;
	logic       addr_stage      = 1'b0;
	logic       writing         = 1'b0;
	logic       in_ack          = 1'b0;
	logic [1:0] last_code       = STATUS_OK;

	// Bus outputs predicted for accepted ticks, oldest first.
	result_t bus_outputs_due[$];

	// Traffic shaping shared by the sender and the receiver.
	bit steady      = 1'b0;
	int hold_wanted = 0;
	int hold_left   = 0;
	int stretch_pct = 25;

	int mismatches   = 0;
	int items_sent   = 0;
	int transfers    = 0;
	int refusals     = 0;
	int reads_seen   = 0;
	int writes_taken = 0;
	int cfg_writes   = 0;

	// A wait register of zero still lasts one tick.
	function automatic logic [WAIT_COUNT_BITS:0] ticks_of(input cfg_wait_t v);
		return (v == '0) ? {{WAIT_COUNT_BITS{1'b0}}, 1'b1} : {1'b0, v};
	endfunction

	// Counts one tick of a half-bit wait; true on its last tick, which also clears the count.
	function automatic logic half_elapsed(input cfg_wait_t v);
		if ({1'b0, tick_count} + 1'b1 >= ticks_of(v)) begin
			tick_count = '0;
			return 1'b1;
		end
		tick_count = tick_count + 1'b1;
		return 1'b0;
	endfunction

	function automatic void load_slot(input logic [7:0] data, input logic ack);
		shifter    = data;
		in_ack     = ack;
		bits_done  = '0;
		tick_count = '0;
		bus_phase  = PH_BIT_LOW;
	endfunction

	// The master owns SDA for the address and written bytes and for the acks it gives on reads.
	function automatic logic master_on_sda();
		if (in_ack) begin
			return !addr_stage && !writing;
		end
		return addr_stage || writing;
	endfunction

	// Advances the bench sequencer by one tick and returns the bus outputs for that tick.
	function automatic result_t advance_engine(input item_t it);
		result_t r;
		r = '0;
		case (bus_phase)
			PH_IDLE, PH_IDLE_HELD: begin
				if (it.command) begin
					shifter         = {it.target_address, it.read_not_write};
					writing         = !it.read_not_write;
					bytes_remaining = it.byte_count;
					addr_stage      = 1'b1;
					in_ack          = 1'b0;
					bits_done       = '0;
					tick_count      = '0;
					bus_phase       = PH_START_SCL;
				end
			end
			PH_START_SCL: begin
				if (it.scl_in) begin
					tick_count = '0;
					bus_phase  = PH_START_SETUP;
				end
			end
			PH_START_SETUP: begin
				if (half_elapsed(cfg_fast ? cfg_high : cfg_low)) begin
					bus_phase = PH_START_HOLD;
				end
			end
			PH_START_HOLD: begin
				if (half_elapsed(cfg_high)) begin
					load_slot(shifter, 1'b0);
				end
			end
			PH_BIT_LOW: begin
				if (half_elapsed(cfg_low)) begin
					bus_phase = PH_BIT_SCL;
				end
			end
			PH_BIT_SCL: begin
				// The high half only starts counting once SCL is really high.
				if (it.scl_in) begin
					tick_count = '0;
					bus_phase  = PH_BIT_HIGH;
				end
			end
			PH_BIT_HIGH: begin
				if (half_elapsed(cfg_high)) begin
					shifter   = {shifter[6:0], it.sda_in};
					bits_done = bits_done + 1'b1;
					if (bits_done >= (in_ack ? ACK_SLOT_BITS : DATA_SLOT_BITS)) begin
						bus_phase = PH_SLOT_TAIL;
					end else begin
						bus_phase = PH_BIT_LOW;
					end
				end
			end
			PH_SLOT_TAIL: begin
				if (half_elapsed(cfg_low)) begin
					if (!in_ack) begin
						if (!addr_stage && !writing) begin
							// A byte came in; the last one of the read is answered with NACK.
							r.read_data     = shifter;
							r.read_valid    = 1'b1;
							bytes_remaining = bytes_remaining - 1'b1;
							load_slot((bytes_remaining == '0) ? SHIFT_ONES : SHIFT_ZEROS, 1'b1);
						end else begin
							load_slot(SHIFT_ONES, 1'b1);
						end
					end else if (addr_stage || writing) begin
						if (shifter[0]) begin
							// Refused by the target: stop at once, holding SCL low.
							last_code = addr_stage ? STATUS_NACK_ADDR : STATUS_NACK_DATA;
							r.done_res = 1'b1;
							bus_phase  = PH_IDLE_HELD;
						end else begin
							addr_stage = 1'b0;
							if (bytes_remaining == '0) begin
								bus_phase = PH_STOP_SCL;
							end else if (writing) begin
								r.write_taken   = 1'b1;
								bytes_remaining = bytes_remaining - 1'b1;
								load_slot(it.write_byte, 1'b0);
							end else begin
								load_slot(SHIFT_ONES, 1'b0);
							end
						end
					end else if (bytes_remaining == '0) begin
						bus_phase = PH_STOP_SCL;
					end else begin
						load_slot(SHIFT_ONES, 1'b0);
					end
				end
			end
			PH_STOP_SCL: begin
				if (it.scl_in) begin
					tick_count = '0;
					bus_phase  = PH_STOP_HOLD;
				end
			end
			PH_STOP_HOLD: begin
				if (half_elapsed(cfg_high)) begin
					bus_phase = PH_STOP_FREE;
				end
			end
			PH_STOP_FREE: begin
				if (half_elapsed(cfg_low)) begin
					last_code  = STATUS_OK;
					r.done_res = 1'b1;
					bus_phase  = PH_IDLE;
				end
			end
			default: begin
				bus_phase = PH_IDLE;
			end
		endcase

		// Line drive follows the phase that the tick ends in.
		case (bus_phase)
			PH_IDLE_HELD: begin
				r.scl_low = 1'b1;
			end
			PH_START_HOLD, PH_STOP_SCL, PH_STOP_HOLD: begin
				r.sda_low = 1'b1;
			end
			PH_BIT_LOW: begin
				r.scl_low = 1'b1;
				r.sda_low = master_on_sda() && !shifter[7];
			end
			PH_BIT_SCL, PH_BIT_HIGH: begin
				r.sda_low = master_on_sda() && !shifter[7];
			end
			PH_SLOT_TAIL: begin
				r.scl_low = 1'b1;
			end
			default: begin
			end
		endcase
		r.busy_res = (bus_phase != PH_IDLE) && (bus_phase != PH_IDLE_HELD);
		r.status   = last_code;
		return r;
	endfunction

	function automatic logic engine_busy();
		return (bus_phase != PH_IDLE) && (bus_phase != PH_IDLE_HELD);
	endfunction

	// True while the target is the one to answer the ack bit of the current slot.
	function automatic logic target_answers();
		return (bus_phase == PH_BIT_HIGH) && in_ack && (addr_stage || writing);
	endfunction

	// A tick with random content; SCL is held low by the target now and then while the
	// engine waits for it, which models clock stretching.
	function automatic item_t random_tick();
		item_t it;
		it.command        = 1'b0;
		it.target_address = 7'($urandom_range(127));
		it.read_not_write = 1'($urandom_range(1));
		it.byte_count     = 8'($urandom_range(255));
		it.write_byte     = 8'($urandom_range(255));
		if (bus_phase inside {PH_START_SCL, PH_BIT_SCL, PH_STOP_SCL}) begin
			it.scl_in = ($urandom_range(99) >= stretch_pct);
		end else begin
			it.scl_in = ($urandom_range(99) < 85);
		end
		it.sda_in = 1'($urandom_range(1));
		return it;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= 40) begin
			$display("%0t: %s got %0d, expected %0d", $time, what, got, want);
		end
	endtask

	// Offers one tick, waits for the handshake and records its predicted outputs.
	task automatic send_tick(input item_t it);
		result_t r;
		if (!steady) begin
			while ($urandom_range(99) < 31) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid       <= 1'b1;
		command        <= it.command;
		target_address <= it.target_address;
		read_not_write <= it.read_not_write;
		byte_count     <= it.byte_count;
		write_byte     <= it.write_byte;
		scl_in         <= it.scl_in;
		sda_in         <= it.sda_in;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		r = advance_engine(it);
		bus_outputs_due.push_back(r);
		items_sent++;
		reads_seen   += r.read_valid;
		writes_taken += r.write_taken;
		if (r.done_res && r.status != STATUS_OK) begin
			refusals++;
		end
	endtask

	// Stops offering ticks and waits until every predicted result has come out.
	task automatic drain(input int extra);
		in_valid <= 1'b0;
		while (bus_outputs_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (extra) @(posedge clk);
	endtask

	task automatic program_reg(input cfg_reg_t idx, input cfg_wait_t value);
		drain(4);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		case (idx)
			REG_LOW_WAIT:  cfg_low  = value;
			REG_HIGH_WAIT: cfg_high = value;
			REG_FAST_MODE: cfg_fast = value[0];
			default: begin
			end
		endcase
		cfg_writes++;
	endtask

	task automatic set_timing(input cfg_wait_t low, input cfg_wait_t high, input logic fast);
		program_reg(REG_LOW_WAIT, low);
		program_reg(REG_HIGH_WAIT, high);
		program_reg(REG_FAST_MODE, {{(CFG_DATA_BITS-1){1'b0}}, fast});
	endtask

	// Runs the engine back to idle, refusing every ack so that a write ends quickly.
	task automatic settle();
		item_t it;
		while (engine_busy()) begin
			it = random_tick();
			if (target_answers()) begin
				it.sda_in = 1'b1;
			end
			send_tick(it);
		end
	endtask

	// Random ticks; a few of them start a short transfer with random acks.
	task automatic run_noise(input int n);
		item_t it;
		repeat (n) begin
			it = random_tick();
			if ($urandom_range(99) < 5) begin
				it.command    = 1'b1;
				it.byte_count = 8'($urandom_range(3));
			end
			send_tick(it);
		end
	endtask

	// One well-formed transfer from the target's point of view: it acks every slot but the
	// one numbered nack_slot (0 is the address). Commands during the transfer must be ignored.
	task automatic run_transfer(input logic [6:0] addr, input logic rnw, input logic [7:0] count,
			input int nack_slot, input int budget);
		item_t it;
		int    acks;
		int    left;
		logic  was_ack;
		settle();
		acks = 0;
		left = budget;
		it = random_tick();
		it.command        = 1'b1;
		it.target_address = addr;
		it.read_not_write = rnw;
		it.byte_count     = count;
		send_tick(it);
		transfers++;
		while (engine_busy() && left > 0) begin
			it = random_tick();
			it.command = ($urandom_range(99) < 8);
			if (target_answers()) begin
				it.sda_in = (acks == nack_slot);
			end
			was_ack = (bus_phase == PH_BIT_HIGH) && in_ack;
			send_tick(it);
			if (was_ack && bus_phase == PH_SLOT_TAIL) begin
				acks++;
			end
			left--;
		end
	endtask

	task automatic random_transfer();
		logic [6:0] addr;
		logic       rnw;
		logic [7:0] count;
		int         nack;
		addr = 7'($urandom_range(127));
		rnw  = 1'($urandom_range(1));
		if ($urandom_range(99) < 6) begin
			// Long counts only with a refused address, to keep the run short.
			count = 8'($urandom_range(255));
			nack  = 0;
		end else begin
			count = 8'($urandom_range(3));
			nack  = ($urandom_range(99) < 75) ? -1 : int'($urandom_range(count));
		end
		run_transfer(addr, rnw, count, nack, 400);
	endtask

	function automatic cfg_wait_t pick_wait();
		int roll;
		roll = $urandom_range(9);
		if (roll == 0) begin
			return '0;
		end else if (roll < 7) begin
			return cfg_wait_t'($urandom_range(1, 3));
		end
		return cfg_wait_t'($urandom_range(4, 8));
	endfunction

	// The reset register values must already give a working bus.
	task automatic test_reset_timing();
		run_transfer(7'h50, 1'b0, 8'd1, -1, 4000);
	endtask

	// Zero waits count as one tick; an address refused at once leaves SCL held low.
	task automatic test_zero_waits_address_nack();
		set_timing('0, '0, 1'b1);
		run_transfer(7'h7F, 1'b0, 8'hFF, 0, 4000);
		run_noise(4);
	endtask

	task automatic test_data_nack();
		run_transfer(7'h00, 1'b0, 8'd3, 2, 4000);
	endtask

	task automatic test_zero_count();
		set_timing(10'd1, 10'd2, 1'b0);
		run_transfer(7'h3C, 1'b0, 8'd0, -1, 4000);
		run_transfer(7'h43, 1'b1, 8'd0, -1, 4000);
	endtask

	task automatic test_read_bytes();
		run_transfer(7'h55, 1'b1, 8'd3, -1, 4000);
	endtask

	// Largest waits: get well into the START setup, then cut the waits short
	// while the counter is far past the new limit.
	task automatic test_extreme_waits();
		set_timing(10'd1023, 10'd1023, 1'b0);
		run_transfer(7'h2A, 1'b0, 8'd1, -1, 150);
		set_timing(10'd1, 10'd2, 1'b1);
		settle();
	endtask

	// No idling on either side, and a long receiver hold-off in each transfer while ticks keep coming.
	task automatic test_back_pressure();
		steady = 1'b1;
		hold_wanted = 80;
		run_transfer(7'h11, 1'b0, 8'd2, -1, 4000);
		hold_wanted = 120;
		run_transfer(7'h6E, 1'b1, 8'd2, -1, 4000);
		steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		int phase_end;
		while (items_sent < 1850) begin
			set_timing(pick_wait(), pick_wait(), 1'($urandom_range(1)));
			stretch_pct = $urandom_range(0, 50);
			phase_end = items_sent + 250;
			while (items_sent < phase_end && items_sent < 1850) begin
				if ($urandom_range(99) < 20) begin
					run_noise($urandom_range(1, 12));
				end else begin
					random_transfer();
				end
			end
		end
	endtask

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_wanted > 0) begin
			hold_left   = hold_wanted;
			hold_wanted = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !steady && ($urandom_range(99) < 31);
		end
	end

	// Each result that moves is compared with the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (bus_outputs_due.size() == 0) begin
				report_mismatch("result with nothing expected, scl_low", scl_low, 0);
			end else begin
				want = bus_outputs_due.pop_front();
				if (scl_low !== want.scl_low)
					report_mismatch("scl_low", scl_low, want.scl_low);
				if (sda_low !== want.sda_low)
					report_mismatch("sda_low", sda_low, want.sda_low);
				if (busy_res !== want.busy_res)
					report_mismatch("busy_res", busy_res, want.busy_res);
				if (write_taken !== want.write_taken)
					report_mismatch("write_taken", write_taken, want.write_taken);
				if (read_data !== want.read_data)
					report_mismatch("read_data", read_data, want.read_data);
				if (read_valid !== want.read_valid)
					report_mismatch("read_valid", read_valid, want.read_valid);
				if (done_res !== want.done_res)
					report_mismatch("done_res", done_res, want.done_res);
				if (status !== want.status)
					report_mismatch("status", status, want.status);
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_timing();
		test_zero_waits_address_nack();
		test_data_nack();
		test_zero_count();
		test_read_bytes();
		test_extreme_waits();
		test_back_pressure();
		test_random_traffic();

		drain(8);
		$display("Ran %0d bus ticks over %0d transfers, %0d refused by the target.",
			items_sent, transfers, refusals);
		$display("Received %0d bytes, sent %0d bytes, %0d register writes.",
			reads_seen, writes_taken, cfg_writes);
		if (mismatches == 0) begin
			$display("i2c_master_transaction_engine_core: match");
		end else begin
			$display("i2c_master_transaction_engine_core: mismatch");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("i2c_master_transaction_engine_core: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/i2cmte_pkg.sv
sv/i2cmte_engine.sv
sv/i2c_master_transaction_engine_core.sv
tb/testbench.sv
